>>> rtl/core/fenwick_prefix_sum_table_unit_macros.svh
// ----------------------------------------------------------------------------
// Fenwick prefix-sum table: assertion macros
// Shorthand for clocked assertions that are disabled while reset is held.
// ----------------------------------------------------------------------------
`ifndef FENWICK_PREFIX_SUM_TABLE_UNIT_MACROS_SVH
`define FENWICK_PREFIX_SUM_TABLE_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define FPST_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define FPST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/fpst_pkg.sv
// ----------------------------------------------------------------------------
// Fenwick prefix-sum table: shared package
// Sizes, the controller state type and the command/status structs.
// ----------------------------------------------------------------------------
`default_nettype none

package fpst_pkg;

    localparam int SIZE   = 1024;
    localparam int ADDR_W = $clog2(SIZE);
    localparam int IDX_W  = ADDR_W + 2;
    localparam int POS_W  = 11;
    localparam int DATA_W = 32;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_UPD   = 4'b0100,
        ST_QRY   = 4'b1000
    } t_state;

    typedef struct packed {
        logic load;
        logic clr_step;
        logic upd_step;
        logic qry_step;
        logic emit_zero;
    } t_ctrl_cmd;

    typedef struct packed {
        logic clr_last;
        logic upd_last;
        logic qry_last;
        logic pos_ok;
        logic pos_zero;
    } t_dp_status;

endpackage

`default_nettype wire

>>> rtl/core/fenwick_prefix_sum_table_unit.sv
// An update keeps busy high while it visits the tree cells on its walk (1 to 11 for
//   1024 cells); a query visits 1 to 10 cells the same way and its result strobes
//   in the cycle after the last visit. A query at position zero answers next cycle.
// One transaction at a time: a start is taken only in idle, while busy is low.
// Reset: synchronous, active low; afterwards a clearing pass that zeroes every cell holds busy high.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
// Fenwick prefix-sum table unit
// Binary indexed tree of signed 32-bit cells with point update and prefix query.
// ----------------------------------------------------------------------------
`default_nettype none

module fenwick_prefix_sum_table_unit (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic                                i_func,
    input  wire logic [fpst_pkg::POS_W-1:0]          i_position,
    input  wire logic signed [fpst_pkg::DATA_W-1:0]  i_delta,
    output logic                                     o_valid,
    output logic signed [fpst_pkg::DATA_W-1:0]       o_prefix_sum
);

    import fpst_pkg::*;

    // The controller and datapath talk only through these two structs.
    t_ctrl_cmd  w_cmd;
    t_dp_status w_status;

    // The controller owns the state machine. After reset it sweeps the tree
    // memory to zero, one cell per cycle, then waits for a transaction. An
    // update walks upward through the tree: each cycle it writes the cell read
    // in the previous cycle plus the delta and reads the next cell. A query
    // walks downward and accumulates the cells it reads. Updates at position
    // zero or beyond the table are dropped without leaving idle.
    fpst_controller u_controller (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_func   (i_func),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (busy),
        .o_valid  (o_valid)
    );

    // The datapath holds the tree memory, the walking index, the delta, the
    // running sum and the registered result. The first read of every walk is
    // issued straight from the input position when the transaction is taken.
    fpst_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_position   (i_position),
        .i_delta      (i_delta),
        .o_status     (w_status),
        .o_prefix_sum (o_prefix_sum)
    );

endmodule

`default_nettype wire

>>> rtl/core/fpst_ram.sv
// ----------------------------------------------------------------------------
// Fenwick prefix-sum table: generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fpst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> rtl/core/fpst_datapath.sv
// ----------------------------------------------------------------------------
// Fenwick prefix-sum table: datapath
// Tree memory, index walk, delta and accumulator registers, clear counter.
// ----------------------------------------------------------------------------
`default_nettype none

module fpst_datapath (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire fpst_pkg::t_ctrl_cmd             i_cmd,
    input  wire logic [fpst_pkg::POS_W-1:0]      i_position,
    input  wire logic signed [fpst_pkg::DATA_W-1:0] i_delta,
    output fpst_pkg::t_dp_status                 o_status,
    output logic signed [fpst_pkg::DATA_W-1:0]   o_prefix_sum
);

    import fpst_pkg::*;

    logic [IDX_W-1:0]  r_idx;
    logic [DATA_W-1:0] r_delta;
    logic [DATA_W-1:0] r_acc;
    logic [DATA_W-1:0] r_sum;
    logic [ADDR_W-1:0] r_clr;

    logic [IDX_W-1:0]  w_start_idx;
    logic [IDX_W-1:0]  w_lowbit;
    logic [IDX_W-1:0]  w_up_idx;
    logic [IDX_W-1:0]  w_dn_idx;
    logic [IDX_W-1:0]  w_next_idx;
    logic [IDX_W-1:0]  w_rd_idx;
    logic [IDX_W-1:0]  w_wr_idx;
    logic [DATA_W-1:0] w_rdata;
    logic [DATA_W-1:0] w_cell_sum;
    logic [DATA_W-1:0] w_acc_sum;
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [DATA_W-1:0] w_wdata;

    // Positions above the table size are clamped for queries.
    assign w_start_idx = (i_position > POS_W'(SIZE)) ? IDX_W'(SIZE) : IDX_W'(i_position);

    // Upward walk adds the lowest set bit; downward walk clears it.
    assign w_lowbit = r_idx & (~r_idx + IDX_W'(1));
    assign w_up_idx = r_idx + w_lowbit;
    assign w_dn_idx = r_idx & (r_idx - IDX_W'(1));

    always_comb begin
        if (i_cmd.load) begin
            w_next_idx = w_start_idx;
        end else if (i_cmd.upd_step) begin
            w_next_idx = w_up_idx;
        end else begin
            w_next_idx = w_dn_idx;
        end
    end

    assign w_rd_idx = w_next_idx - IDX_W'(1);
    assign w_wr_idx = r_idx - IDX_W'(1);

    assign w_cell_sum = w_rdata + r_delta;
    assign w_acc_sum  = r_acc + w_rdata;

    assign w_we    = i_cmd.clr_step | i_cmd.upd_step;
    assign w_waddr = i_cmd.clr_step ? r_clr : w_wr_idx[ADDR_W-1:0];
    assign w_wdata = i_cmd.clr_step ? '0 : w_cell_sum;

    fpst_ram #(
        .WIDTH (DATA_W),
        .DEPTH (SIZE)
    ) u_tree_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_rd_idx[ADDR_W-1:0]),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr <= r_clr + ADDR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_idx   <= w_start_idx;
            r_delta <= i_delta;
            r_acc   <= '0;
        end else if (i_cmd.upd_step) begin
            r_idx <= w_up_idx;
        end else if (i_cmd.qry_step) begin
            r_idx <= w_dn_idx;
            r_acc <= w_acc_sum;
        end
        if (i_cmd.emit_zero) begin
            r_sum <= '0;
        end else if (i_cmd.qry_step) begin
            r_sum <= w_acc_sum;
        end
    end

    assign o_status.clr_last = (r_clr == ADDR_W'(SIZE - 1));
    assign o_status.upd_last = (w_up_idx > IDX_W'(SIZE));
    assign o_status.qry_last = (w_dn_idx == '0);
    assign o_status.pos_ok   = (i_position != '0) && (i_position <= POS_W'(SIZE));
    assign o_status.pos_zero = (i_position == '0);

    assign o_prefix_sum = $signed(r_sum);

endmodule

`default_nettype wire

>>> rtl/core/fpst_controller.sv
// ----------------------------------------------------------------------------
// Fenwick prefix-sum table: controller
// Sequences the clearing pass, update walks and query walks.
// ----------------------------------------------------------------------------
`default_nettype none

module fpst_controller (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic                 i_func,
    input  wire fpst_pkg::t_dp_status i_status,
    output fpst_pkg::t_ctrl_cmd       o_cmd,
    output logic                      o_busy,
    output logic                      o_valid
);

    import fpst_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_valid;
    logic   n_valid;

    always_comb begin
        n_state = r_state;
        n_valid = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (!i_func) begin
                        if (i_status.pos_ok) begin
                            n_state = ST_UPD;
                        end
                    end else if (i_status.pos_zero) begin
                        o_cmd.emit_zero = 1'b1;
                        n_valid         = 1'b1;
                    end else begin
                        n_state = ST_QRY;
                    end
                end
            end
            ST_UPD: begin
                o_cmd.upd_step = 1'b1;
                if (i_status.upd_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_QRY: begin
                o_cmd.qry_step = 1'b1;
                if (i_status.qry_last) begin
                    n_valid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign o_busy  = (r_state != ST_IDLE);
    assign o_valid = r_valid;

endmodule

`default_nettype wire

>>> rtl/core/fpst_checker.sv
// ----------------------------------------------------------------------------
// Fenwick prefix-sum table: port checker
// Watches the top-level ports for result strobes that do not fit a transaction.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fenwick_prefix_sum_table_unit_macros.svh"

module fpst_checker (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                start,
    input wire logic                                busy,
    input wire logic                                i_func,
    input wire logic [fpst_pkg::POS_W-1:0]          i_position,
    input wire logic                                o_valid,
    input wire logic signed [fpst_pkg::DATA_W-1:0]  o_prefix_sum
);

    // An idle cycle with no transaction cannot produce a result.
    `FPST_ASSERT_NEXT(a_no_spurious_result, !busy && !start, !o_valid, "result without transaction")

    // An update never returns a result.
    `FPST_ASSERT_NEXT(a_update_silent, start && !busy && !i_func, !o_valid, "update gave a result")

    // A query at position zero answers zero in the next cycle.
    `FPST_ASSERT_NEXT(a_zero_query, start && !busy && i_func && (i_position == '0), o_valid && (o_prefix_sum == '0), "query at zero wrong")

    // A result always follows work in progress or a fresh transaction.
    `FPST_ASSERT_SAME(a_result_has_cause, o_valid, $past(busy) || $past(start), "result without cause")

endmodule

bind fenwick_prefix_sum_table_unit fpst_checker u_fpst_checker (.*);

`default_nettype wire

>>> test/fenwick_prefix_sum_table_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Fenwick prefix-sum table: transaction checker
// Watches the command and result channels. It keeps its own copy of the tree,
// predicts each query's sum and compares it with the next strobed result.
// ----------------------------------------------------------------------------

package fpst_tb_pkg;

    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

endpackage

module fenwick_prefix_sum_table_checker
    import fpst_tb_pkg::*;
(
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic                                i_func,
    input  logic [fpst_pkg::POS_W-1:0]          i_position,
    input  logic signed [fpst_pkg::DATA_W-1:0]  i_delta,
    input  logic                                o_valid,
    input  logic signed [fpst_pkg::DATA_W-1:0]  o_prefix_sum,
    output int                                  error_count,
    output int                                  outstanding,
    output int                                  sums_checked
);

    localparam int unsigned CELLS = fpst_pkg::SIZE;

    // Shadow tree, indexed from 1 like the positions themselves.
    logic [fpst_pkg::DATA_W-1:0] shadow_tree [1:CELLS];
    logic [fpst_pkg::DATA_W-1:0] pending_sums [$];

    function automatic void add_at_position(input logic [fpst_pkg::POS_W-1:0] pos,
                                            input logic [fpst_pkg::DATA_W-1:0] amount);
        int unsigned k;
        k = 32'(pos);
        if (k == 0 || k > CELLS) begin
            return;
        end
        while (k <= CELLS) begin
            shadow_tree[k] = shadow_tree[k] + amount;
            k = k + (k & (~k + 1));
        end
    endfunction

    function automatic logic [fpst_pkg::DATA_W-1:0] prefix_total(
            input logic [fpst_pkg::POS_W-1:0] pos);
        int unsigned p;
        logic [fpst_pkg::DATA_W-1:0] acc;
        p   = (pos > CELLS) ? CELLS : 32'(pos);
        acc = '0;
        while (p != 0) begin
            acc = acc + shadow_tree[p];
            p   = p & (p - 1);
        end
        return acc;
    endfunction

    always @(posedge i_clk) begin : watch
        logic [fpst_pkg::DATA_W-1:0] oldest;
        if (!i_rst_n) begin
            for (int unsigned i = 1; i <= CELLS; i++) begin
                shadow_tree[i] = '0;
            end
            pending_sums.delete();
            error_count  = 0;
            sums_checked = 0;
        end else begin
            // Results first: a new command accepted on this edge cannot have
            // produced its answer yet.
            if (o_valid) begin
                if (pending_sums.size() == 0) begin
                    $error("prefix_sum: result %0d strobed with no query waiting",
                           o_prefix_sum);
                    error_count++;
                end else begin
                    oldest = pending_sums.pop_front();
                    sums_checked++;
                    if (o_prefix_sum !== oldest) begin
                        $error("prefix_sum: expected %0d, got %0d",
                               $signed(oldest), o_prefix_sum);
                        error_count++;
                    end
                end
            end
            if (start && !busy) begin
                if (i_func == FUNC_QUERY) begin
                    pending_sums = {pending_sums, prefix_total(i_position)};
                end else begin
                    add_at_position(i_position, i_delta);
                end
            end
        end
        outstanding = pending_sums.size();
    end

endmodule

>>> test/tb_fenwick_prefix_sum_table_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Fenwick prefix-sum table unit: testbench
// Drives point updates and prefix queries in random bursts after a directed
// opening; the checker beside the block predicts and compares every sum.
// ----------------------------------------------------------------------------

module tb_fenwick_prefix_sum_table_unit;

    import fpst_tb_pkg::*;

    localparam int POS_W        = fpst_pkg::POS_W;
    localparam int DATA_W       = fpst_pkg::DATA_W;
    localparam int CELLS        = fpst_pkg::SIZE;
    localparam int RANDOM_ITEMS = 750;
    // The clearing pass after reset and every transaction with its gap fit
    // in this limit many times over.
    localparam int CYCLE_LIMIT  = 200_000;
    // Cycles left to run after the last expected sum, well past one walk.
    localparam int DRAIN_CYCLES = 30;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic                      i_func;
    logic [POS_W-1:0]          i_position;
    logic signed [DATA_W-1:0]  i_delta;
    logic                      o_valid;
    logic signed [DATA_W-1:0]  o_prefix_sum;

    int error_count;
    int outstanding;
    int sums_checked;
    int cycle_count = 0;

    // Tallies for the closing summary.
    int update_count;
    int ignored_updates;
    int query_count;

    fenwick_prefix_sum_table_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_func       (i_func),
        .i_position   (i_position),
        .i_delta      (i_delta),
        .o_valid      (o_valid),
        .o_prefix_sum (o_prefix_sum)
    );

    fenwick_prefix_sum_table_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_func       (i_func),
        .i_position   (i_position),
        .i_delta      (i_delta),
        .o_valid      (o_valid),
        .o_prefix_sum (o_prefix_sum),
        .error_count  (error_count),
        .outstanding  (outstanding),
        .sums_checked (sums_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d sums still expected",
                     cycle_count, outstanding);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Presents one transaction at the falling edge and holds it until the
    // block takes it, i.e. a rising edge with busy low. Start stays high on
    // return, so a back-to-back transaction just overwrites the fields at the
    // next falling edge.
    task automatic drive_command(input logic func, input logic [POS_W-1:0] pos,
                                 input logic [DATA_W-1:0] delta);
        @(negedge i_clk);
        start      <= 1'b1;
        i_func     <= func;
        i_position <= pos;
        i_delta    <= delta;
        do begin
            @(posedge i_clk);
        end while (busy);
        if (func == FUNC_QUERY) begin
            query_count++;
        end else begin
            update_count++;
            if (pos == 0 || pos > CELLS) begin
                ignored_updates++;
            end
        end
    endtask

    // Lowers start for the given number of falling edges; the fields keep
    // whatever they last held.
    task automatic idle_for(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
    endtask

    // Positions lean toward the legal range, with a share of zero, of
    // out-of-range values and of powers of two where the walks are longest
    // or shortest. Deltas mix small signed values, the extremes and noise.
    task automatic pick_command(output logic func, output logic [POS_W-1:0] pos,
                                output logic [DATA_W-1:0] delta);
        int roll;
        roll = $urandom_range(0, 99);
        func = $urandom_range(0, 1) ? FUNC_QUERY : FUNC_ADD;
        if (roll < 4) begin
            pos = '0;
        end else if (roll < 10) begin
            pos = POS_W'($urandom_range(CELLS + 1, (1 << POS_W) - 1));
        end else if (roll < 20) begin
            pos = POS_W'(1 << $urandom_range(0, 10));
            if ($urandom_range(0, 1) && pos > 1) begin
                pos = pos - POS_W'(1);
            end
        end else begin
            pos = POS_W'($urandom_range(1, CELLS));
        end
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
            delta = 32'h7FFF_FFFF;
        end else if (roll < 8) begin
            delta = 32'h8000_0000;
        end else if (roll < 12) begin
            delta = 32'hFFFF_FFFF;
        end else if (roll < 45) begin
            delta = DATA_W'($urandom_range(0, 400)) - 32'd200;
        end else begin
            delta = $urandom();
        end
    endtask

    initial begin : stimulus
        logic              func;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] delta;
        int                counted;
        int                burst;

        update_count    = 0;
        ignored_updates = 0;
        query_count     = 0;
        start           = 1'b0;
        i_func          = FUNC_ADD;
        i_position      = '0;
        i_delta         = '0;
        i_rst_n         = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed opening. The table starts empty, so the first queries
        // must read zero whatever the position.
        drive_command(FUNC_QUERY, 11'd0,    32'h0);
        drive_command(FUNC_QUERY, 11'd1024, 32'h0);
        drive_command(FUNC_QUERY, 11'd2047, 32'hFFFF_FFFF);
        // Updates at position zero and beyond the table must change nothing.
        drive_command(FUNC_ADD,   11'd0,    32'h1234_5678);
        drive_command(FUNC_ADD,   11'd1025, 32'h0BAD_F00D);
        drive_command(FUNC_ADD,   11'd2047, 32'hFFFF_FFFF);
        drive_command(FUNC_QUERY, 11'd1024, 32'h0);
        // Largest positive delta, then one more to wrap past the top.
        drive_command(FUNC_ADD,   11'd1,    32'h7FFF_FFFF);
        drive_command(FUNC_ADD,   11'd1,    32'h0000_0001);
        drive_command(FUNC_QUERY, 11'd1,    32'h0);
        drive_command(FUNC_ADD,   11'd1024, 32'h8000_0000);
        drive_command(FUNC_ADD,   11'd512,  32'hFFFF_FFFF);
        drive_command(FUNC_ADD,   11'd1023, 32'd77);
        drive_command(FUNC_ADD,   11'd682,  32'h5555_5555);
        // Long and short walks, the clamped query and a query whose delta
        // field is not zero.
        drive_command(FUNC_QUERY, 11'd512,  32'h0);
        drive_command(FUNC_QUERY, 11'd1023, 32'h0);
        drive_command(FUNC_QUERY, 11'd1024, 32'hFFFF_FFFF);
        drive_command(FUNC_QUERY, 11'd1025, 32'h8000_0000);
        drive_command(FUNC_QUERY, 11'd2047, 32'h0);
        drive_command(FUNC_QUERY, 11'd683,  32'h7FFF_FFFF);
        drive_command(FUNC_QUERY, 11'd0,    32'h7FFF_FFFF);
        idle_for(3);

        // Random bursts. Ignored updates do not count toward the total.
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 24);
            repeat (burst) begin
                pick_command(func, pos, delta);
                drive_command(func, pos, delta);
                if (func == FUNC_QUERY || (pos != 0 && pos <= CELLS)) begin
                    counted++;
                end
            end
            // About a third of the bursts run straight into the next one.
            if ($urandom_range(0, 2) != 0) begin
                idle_for($urandom_range(1, 14));
            end
        end
        idle_for(1);

        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d updates (%0d off the table) and %0d queries;",
                 update_count, ignored_updates, query_count);
        $display("%0d prefix sums were compared against the shadow tree.", sums_checked);
        if (error_count == 0 && outstanding == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
